// ----- sv/swsr_pkg.sv -----
`default_nettype none

package swsr_pkg;

    // Tick counter and timing register width
    localparam int COUNTER_WIDTH = 16;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    // Configuration port geometry
    localparam int NUM_REGS   = 6;
    localparam int ADDR_WIDTH = $clog2(NUM_REGS) + 2;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_WIDTH  = ADDR_WIDTH - 2;

    // Register indexes
    localparam logic [IDX_WIDTH-1:0] REG_START_LOW      = IDX_WIDTH'(0);
    localparam logic [IDX_WIDTH-1:0] REG_START_HIGH     = IDX_WIDTH'(1);
    localparam logic [IDX_WIDTH-1:0] REG_RESPONSE_WAIT  = IDX_WIDTH'(2);
    localparam logic [IDX_WIDTH-1:0] REG_RESPONSE_CHECK = IDX_WIDTH'(3);
    localparam logic [IDX_WIDTH-1:0] REG_BIT_SAMPLE     = IDX_WIDTH'(4);
    localparam logic [IDX_WIDTH-1:0] REG_BYTES_FRAME    = IDX_WIDTH'(5);

    // Reset values
    localparam logic [COUNTER_WIDTH-1:0] RST_START_LOW      = COUNTER_WIDTH'(1200);
    localparam logic [COUNTER_WIDTH-1:0] RST_START_HIGH     = COUNTER_WIDTH'(20);
    localparam logic [COUNTER_WIDTH-1:0] RST_RESPONSE_WAIT  = COUNTER_WIDTH'(40);
    localparam logic [COUNTER_WIDTH-1:0] RST_RESPONSE_CHECK = COUNTER_WIDTH'(80);
    localparam logic [COUNTER_WIDTH-1:0] RST_BIT_SAMPLE     = COUNTER_WIDTH'(40);
    localparam logic [3:0]               RST_BYTES_FRAME    = 4'd5;

    // Line drive codes
    localparam logic [1:0] DRIVE_RELEASE = 2'd0;
    localparam logic [1:0] DRIVE_LOW     = 2'd1;
    localparam logic [1:0] DRIVE_HIGH    = 2'd2;

    // Response status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_NONE = 2'd2;

    // Timing and frame settings handed to the receiver
    typedef struct packed {
        logic [COUNTER_WIDTH-1:0] start_low_ticks;
        logic [COUNTER_WIDTH-1:0] start_high_ticks;
        logic [COUNTER_WIDTH-1:0] response_wait_ticks;
        logic [COUNTER_WIDTH-1:0] response_check_ticks;
        logic [COUNTER_WIDTH-1:0] bit_sample_ticks;
        logic [3:0]               bytes_per_frame;
    } swsr_cfg_t;

endpackage

`default_nettype wire

// ----- sv/swsr_regs.sv -----
`default_nettype none

module swsr_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [swsr_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [swsr_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic      [swsr_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                   pready,
    output swsr_pkg::swsr_cfg_t                    cfg
);
    import swsr_pkg::*;

    swsr_cfg_t             cfg_reg;
    logic                  wr_en;
    logic [IDX_WIDTH-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign cfg     = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks      <= RST_START_LOW;
            cfg_reg.start_high_ticks     <= RST_START_HIGH;
            cfg_reg.response_wait_ticks  <= RST_RESPONSE_WAIT;
            cfg_reg.response_check_ticks <= RST_RESPONSE_CHECK;
            cfg_reg.bit_sample_ticks     <= RST_BIT_SAMPLE;
            cfg_reg.bytes_per_frame      <= RST_BYTES_FRAME;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_LOW:      cfg_reg.start_low_ticks      <= pwdata[COUNTER_WIDTH-1:0];
                REG_START_HIGH:     cfg_reg.start_high_ticks     <= pwdata[COUNTER_WIDTH-1:0];
                REG_RESPONSE_WAIT:  cfg_reg.response_wait_ticks  <= pwdata[COUNTER_WIDTH-1:0];
                REG_RESPONSE_CHECK: cfg_reg.response_check_ticks <= pwdata[COUNTER_WIDTH-1:0];
                REG_BIT_SAMPLE:     cfg_reg.bit_sample_ticks     <= pwdata[COUNTER_WIDTH-1:0];
                REG_BYTES_FRAME:    cfg_reg.bytes_per_frame      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_START_LOW:      prdata = DATA_WIDTH'(cfg_reg.start_low_ticks);
            REG_START_HIGH:     prdata = DATA_WIDTH'(cfg_reg.start_high_ticks);
            REG_RESPONSE_WAIT:  prdata = DATA_WIDTH'(cfg_reg.response_wait_ticks);
            REG_RESPONSE_CHECK: prdata = DATA_WIDTH'(cfg_reg.response_check_ticks);
            REG_BIT_SAMPLE:     prdata = DATA_WIDTH'(cfg_reg.bit_sample_ticks);
            REG_BYTES_FRAME:    prdata = DATA_WIDTH'(cfg_reg.bytes_per_frame);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/single_wire_sensor_reader.sv -----
// A tick word accepted at a clock edge has its result word in the result register after that edge.
// Throughput: one tick word per cycle while out_ready drains the result register, set by
// the single registered step from the state and tick word to the result register.
// Reset (rst_n, asynchronous, low): receiver idle, counters and shift byte cleared,
// timing registers at their defaults, no result word held.
`default_nettype none

module single_wire_sensor_reader (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [swsr_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [swsr_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic      [swsr_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                   pready,
    // tick words in
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              start_request,
    input  wire logic                              line_level,
    // result words out
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [1:0]                        line_drive,
    output logic                                   busy_res,
    output logic                                   byte_valid,
    output logic      [7:0]                        received_byte,
    output logic                                   byte_last,
    output logic                                   status_valid,
    output logic      [1:0]                        response_status
);
    import swsr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_LOW        = 4'd1,
        PH_HIGH       = 4'd2,
        PH_WAIT       = 4'd3,
        PH_CHECK      = 4'd4,
        PH_DRAIN_OK   = 4'd5,
        PH_DRAIN_FAIL = 4'd6,
        PH_BIT_HIGH   = 4'd7,
        PH_BIT_DELAY  = 4'd8,
        PH_BIT_LOW    = 4'd9
    } phase_t;

    swsr_cfg_t cfg;

    swsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // State
    phase_t                   phase_reg, phase_next, eff_phase;
    logic [COUNTER_WIDTH-1:0] tick_count_reg, tick_count_next, eff_tick;
    logic [2:0]               bit_index_reg, bit_index_next;
    logic [7:0]               shift_byte_reg, shift_byte_next;
    logic [3:0]               bytes_left_reg, bytes_left_next;

    // Result register
    logic                     out_valid_reg;
    logic [1:0]               line_drive_reg, line_drive_next;
    logic                     busy_reg, busy_next;
    logic                     byte_valid_reg, byte_valid_next;
    logic [7:0]               received_byte_reg, received_byte_next;
    logic                     byte_last_reg, byte_last_next;
    logic                     status_valid_reg, status_valid_next;
    logic [1:0]               status_reg, status_next;

    logic                     in_acc;
    logic [COUNTER_WIDTH-1:0] tick_limit, tick_inc;
    logic                     step_done;
    logic [7:0]               shift_cat;

    // New word taken whenever the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // Start from idle enters the low phase on the same tick
    always_comb
    begin
        eff_phase = phase_reg;
        eff_tick  = tick_count_reg;
        if (phase_reg == PH_IDLE && start_request)
        begin
            eff_phase = PH_LOW;
            eff_tick  = '0;
        end
    end

    // Shared step counter: saturating increment, ends at limit or at max
    always_comb
    begin
        case (eff_phase)
            PH_LOW:   tick_limit = cfg.start_low_ticks;
            PH_HIGH:  tick_limit = cfg.start_high_ticks;
            PH_WAIT:  tick_limit = cfg.response_wait_ticks;
            PH_CHECK: tick_limit = cfg.response_check_ticks;
            default:  tick_limit = cfg.bit_sample_ticks;
        endcase
        tick_inc  = (eff_tick == CNT_MAX) ? eff_tick : eff_tick + 1'b1;
        step_done = (tick_inc >= tick_limit) || (tick_inc == CNT_MAX);
    end

    assign shift_cat = {shift_byte_reg[6:0], line_level};

    // Per-tick step
    always_comb
    begin
        phase_next         = eff_phase;
        tick_count_next    = eff_tick;
        bit_index_next     = bit_index_reg;
        shift_byte_next    = shift_byte_reg;
        bytes_left_next    = bytes_left_reg;
        line_drive_next    = DRIVE_RELEASE;
        busy_next          = (eff_phase != PH_IDLE);
        byte_valid_next    = 1'b0;
        received_byte_next = '0;
        byte_last_next     = 1'b0;
        status_valid_next  = 1'b0;
        status_next        = STATUS_OK;

        case (eff_phase)
            PH_IDLE: ;
            PH_LOW:
            begin
                line_drive_next = DRIVE_LOW;
                tick_count_next = step_done ? '0 : tick_inc;
                if (step_done)
                    phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                line_drive_next = DRIVE_HIGH;
                tick_count_next = step_done ? '0 : tick_inc;
                if (step_done)
                    phase_next = PH_WAIT;
            end
            PH_WAIT:
            begin
                tick_count_next = step_done ? '0 : tick_inc;
                if (step_done)
                begin
                    if (!line_level)
                        phase_next = PH_CHECK;
                    else
                    begin
                        status_valid_next = 1'b1;
                        status_next       = STATUS_NONE;
                        phase_next        = PH_DRAIN_FAIL;
                    end
                end
            end
            PH_CHECK:
            begin
                tick_count_next = step_done ? '0 : tick_inc;
                if (step_done)
                begin
                    status_valid_next = 1'b1;
                    status_next       = line_level ? STATUS_OK : STATUS_BAD;
                    phase_next        = line_level ? PH_DRAIN_OK : PH_DRAIN_FAIL;
                end
            end
            PH_DRAIN_OK:
            begin
                if (!line_level)
                begin
                    bytes_left_next = cfg.bytes_per_frame;
                    bit_index_next  = '0;
                    shift_byte_next = '0;
                    phase_next = (cfg.bytes_per_frame == '0) ? PH_IDLE : PH_BIT_HIGH;
                end
            end
            PH_DRAIN_FAIL:
            begin
                if (!line_level)
                    phase_next = PH_IDLE;
            end
            PH_BIT_HIGH:
            begin
                if (line_level)
                begin
                    tick_count_next = '0;
                    phase_next      = PH_BIT_DELAY;
                end
            end
            PH_BIT_DELAY:
            begin
                tick_count_next = step_done ? '0 : tick_inc;
                if (step_done)
                begin
                    shift_byte_next = shift_cat;
                    if (bit_index_reg == 3'd7)
                    begin
                        byte_valid_next    = 1'b1;
                        received_byte_next = shift_cat;
                        byte_last_next     = (bytes_left_reg == 4'd1);
                        bytes_left_next    = bytes_left_reg - 4'd1;
                        bit_index_next     = '0;
                    end
                    else
                        bit_index_next = bit_index_reg + 3'd1;
                    phase_next = PH_BIT_LOW;
                end
            end
            PH_BIT_LOW:
            begin
                if (!line_level)
                    phase_next = (bytes_left_reg == '0) ? PH_IDLE : PH_BIT_HIGH;
            end
            default:
            begin
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            tick_count_reg    <= '0;
            bit_index_reg     <= '0;
            shift_byte_reg    <= '0;
            bytes_left_reg    <= '0;
            out_valid_reg     <= 1'b0;
            line_drive_reg    <= DRIVE_RELEASE;
            busy_reg          <= 1'b0;
            byte_valid_reg    <= 1'b0;
            received_byte_reg <= '0;
            byte_last_reg     <= 1'b0;
            status_valid_reg  <= 1'b0;
            status_reg        <= STATUS_OK;
        end
        else if (in_acc)
        begin
            phase_reg         <= phase_next;
            tick_count_reg    <= tick_count_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            bytes_left_reg    <= bytes_left_next;
            out_valid_reg     <= 1'b1;
            line_drive_reg    <= line_drive_next;
            busy_reg          <= busy_next;
            byte_valid_reg    <= byte_valid_next;
            received_byte_reg <= received_byte_next;
            byte_last_reg     <= byte_last_next;
            status_valid_reg  <= status_valid_next;
            status_reg        <= status_next;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid       = out_valid_reg;
    assign line_drive      = line_drive_reg;
    assign busy_res        = busy_reg;
    assign byte_valid      = byte_valid_reg;
    assign received_byte   = received_byte_reg;
    assign byte_last       = byte_last_reg;
    assign status_valid    = status_valid_reg;
    assign response_status = status_reg;

    // A byte and a response status never come out on the same tick
    a_byte_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(byte_valid_reg && status_valid_reg))
        else $error("byte and status in one word");

    // Last-byte mark only on a completed byte
    a_last_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        byte_last_reg |-> byte_valid_reg)
        else $error("byte_last without byte_valid");

    // The line is only driven during a transaction
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_drive_reg != DRIVE_RELEASE) |-> busy_reg)
        else $error("line driven while not busy");

    // Idle with no start request stays idle
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && phase_reg == PH_IDLE && !start_request) |=> phase_reg == PH_IDLE)
        else $error("left idle without start");

    // A start from idle shows as a driven-low, busy word
    a_start_drives_low: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && phase_reg == PH_IDLE && start_request)
            |=> (busy_reg && line_drive_reg == DRIVE_LOW))
        else $error("start did not drive the line low");

endmodule

`default_nettype wire

// ----- tb/swsr_tick_checker.sv -----
module swsr_tick_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port, watched for register writes
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swsr_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [swsr_pkg::DATA_WIDTH-1:0] pwdata,
    input  logic                            pready,
    // tick words
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            start_request,
    input  logic                            line_level,
    // result words
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      line_drive,
    input  logic                            busy_res,
    input  logic                            byte_valid,
    input  logic [7:0]                      received_byte,
    input  logic                            byte_last,
    input  logic                            status_valid,
    input  logic [1:0]                      response_status,
    // to the testbench top
    output int                              pending,
    output int                              fail_count,
    output int                              words_checked,
    output int                              bytes_checked,
    output int                              ok_count,
    output int                              bad_count,
    output int                              silent_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import swsr_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef enum logic [3:0] {
        RX_IDLE,
        RX_LOW,
        RX_HIGH,
        RX_WAIT,
        RX_CHECK,
        RX_DRAIN_OK,
        RX_DRAIN_FAIL,
        RX_BIT_HIGH,
        RX_BIT_DELAY,
        RX_BIT_LOW
    } rx_phase_e;

    typedef struct packed {
        logic [1:0] drive;
        logic       busy;
        logic       byte_ok;
        logic [7:0] data;
        logic       last;
        logic       stat_ok;
        logic [1:0] status;
    } tick_result_t;

    // receiver mirror
    swsr_cfg_t                rx_cfg;
    rx_phase_e                rx_phase;
    logic [COUNTER_WIDTH-1:0] tick_cnt;
    logic [2:0]               bit_idx;
    logic [7:0]               shreg;
    logic [3:0]               bytes_left;

    tick_result_t expected_q[$];
    int fails, n_words, n_bytes, n_ok, n_bad, n_silent;

    // one tick of a timed step; true on the tick that ends it (zero limit acts as one)
    function automatic logic step_elapsed(logic [COUNTER_WIDTH-1:0] limit);
        if (tick_cnt != CNT_MAX)
            tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= limit || tick_cnt == CNT_MAX)
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the receiver by one tick word, returning the result word it owes
    function automatic tick_result_t advance_receiver(logic req, logic lvl);
        tick_result_t r;
        r = '0;
        if (rx_phase == RX_IDLE && req)
        begin
            rx_phase = RX_LOW;
            tick_cnt = '0;
        end
        r.busy = (rx_phase != RX_IDLE);

        case (rx_phase)
            RX_LOW:
            begin
                r.drive = DRIVE_LOW;
                if (step_elapsed(rx_cfg.start_low_ticks))
                    rx_phase = RX_HIGH;
            end
            RX_HIGH:
            begin
                r.drive = DRIVE_HIGH;
                if (step_elapsed(rx_cfg.start_high_ticks))
                    rx_phase = RX_WAIT;
            end
            RX_WAIT:
            begin
                if (step_elapsed(rx_cfg.response_wait_ticks))
                begin
                    if (!lvl)
                        rx_phase = RX_CHECK;
                    else
                    begin
                        r.stat_ok = 1'b1;
                        r.status  = STATUS_NONE;
                        rx_phase  = RX_DRAIN_FAIL;
                    end
                end
            end
            RX_CHECK:
            begin
                if (step_elapsed(rx_cfg.response_check_ticks))
                begin
                    r.stat_ok = 1'b1;
                    r.status  = lvl ? STATUS_OK : STATUS_BAD;
                    rx_phase  = lvl ? RX_DRAIN_OK : RX_DRAIN_FAIL;
                end
            end
            RX_DRAIN_OK:
            begin
                if (!lvl)
                begin
                    bytes_left = rx_cfg.bytes_per_frame;
                    bit_idx    = '0;
                    shreg      = '0;
                    rx_phase   = (bytes_left == 0) ? RX_IDLE : RX_BIT_HIGH;
                end
            end
            RX_DRAIN_FAIL:
            begin
                if (!lvl)
                    rx_phase = RX_IDLE;
            end
            RX_BIT_HIGH:
            begin
                if (lvl)
                begin
                    tick_cnt = '0;
                    rx_phase = RX_BIT_DELAY;
                end
            end
            RX_BIT_DELAY:
            begin
                if (step_elapsed(rx_cfg.bit_sample_ticks))
                begin
                    shreg = {shreg[6:0], lvl};
                    if (bit_idx == 3'd7)
                    begin
                        r.byte_ok  = 1'b1;
                        r.data     = shreg;
                        r.last     = (bytes_left == 4'd1);
                        bytes_left = bytes_left - 1'b1;
                        bit_idx    = '0;
                    end
                    else
                        bit_idx = bit_idx + 1'b1;
                    rx_phase = RX_BIT_LOW;
                end
            end
            RX_BIT_LOW:
            begin
                if (!lvl)
                    rx_phase = (bytes_left == 0) ? RX_IDLE : RX_BIT_HIGH;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            rx_cfg     = {RST_START_LOW, RST_START_HIGH, RST_RESPONSE_WAIT,
                          RST_RESPONSE_CHECK, RST_BIT_SAMPLE, RST_BYTES_FRAME};
            rx_phase   = RX_IDLE;
            tick_cnt   = '0;
            bit_idx    = '0;
            shreg      = '0;
            bytes_left = '0;
            expected_q.delete();
            fails    = 0;
            n_words  = 0;
            n_bytes  = 0;
            n_ok     = 0;
            n_bad    = 0;
            n_silent = 0;
        end
        else
        begin
            // register writes land at the access edge
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_WIDTH-1:2])
                    REG_START_LOW:      rx_cfg.start_low_ticks      = pwdata[COUNTER_WIDTH-1:0];
                    REG_START_HIGH:     rx_cfg.start_high_ticks     = pwdata[COUNTER_WIDTH-1:0];
                    REG_RESPONSE_WAIT:  rx_cfg.response_wait_ticks  = pwdata[COUNTER_WIDTH-1:0];
                    REG_RESPONSE_CHECK: rx_cfg.response_check_ticks = pwdata[COUNTER_WIDTH-1:0];
                    REG_BIT_SAMPLE:     rx_cfg.bit_sample_ticks     = pwdata[COUNTER_WIDTH-1:0];
                    REG_BYTES_FRAME:    rx_cfg.bytes_per_frame      = pwdata[3:0];
                    default:
                    begin
                    end
                endcase
            end

            // compare before predicting: a word leaving now cannot belong to a tick entering now
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: result word expected none, actual drive %0d byte %0d",
                                 $time, line_drive, received_byte);
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("line_drive", want.drive, line_drive);
                    compare_field("busy_res", want.busy, busy_res);
                    compare_field("byte_valid", want.byte_ok, byte_valid);
                    compare_field("received_byte", want.data, received_byte);
                    compare_field("byte_last", want.last, byte_last);
                    compare_field("status_valid", want.stat_ok, status_valid);
                    compare_field("response_status", want.status, response_status);
                    n_words++;
                    if (want.byte_ok)
                        n_bytes++;
                    if (want.stat_ok)
                    begin
                        case (want.status)
                            STATUS_OK:  n_ok++;
                            STATUS_BAD: n_bad++;
                            default:    n_silent++;
                        endcase
                    end
                end
            end

            if (in_valid && in_ready)
                expected_q.push_back(advance_receiver(start_request, line_level));
        end

        pending       <= expected_q.size();
        fail_count    <= fails;
        words_checked <= n_words;
        bytes_checked <= n_bytes;
        ok_count      <= n_ok;
        bad_count     <= n_bad;
        silent_count  <= n_silent;
    end

endmodule

// ----- tb/tb_single_wire_sensor_reader.sv -----
module tb_single_wire_sensor_reader;

    timeunit 1ns;
    timeprecision 1ps;

    import swsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_TICKS    = 30;
    localparam int RANDOM_PHASES  = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr   = '0;
    logic [DATA_WIDTH-1:0] pwdata  = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic       start_request = 1'b0;
    logic       line_level    = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [1:0] line_drive;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] received_byte;
    logic       byte_last;
    logic       status_valid;
    logic [1:0] response_status;

    int pending, fail_count, words_checked, bytes_checked;
    int ok_count, bad_count, silent_count;

    int        snd_idle_pct = 0;
    int        rcv_stall_pct = 0;
    int        ticks_sent = 0;
    int        settings_applied = 0;
    int        idle_cycles = 0;
    swsr_cfg_t stim_cfg;

    single_wire_sensor_reader u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_request  (start_request),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_drive     (line_drive),
        .busy_res       (busy_res),
        .byte_valid     (byte_valid),
        .received_byte  (received_byte),
        .byte_last      (byte_last),
        .status_valid   (status_valid),
        .response_status(response_status)
    );

    swsr_tick_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_request  (start_request),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_drive     (line_drive),
        .busy_res       (busy_res),
        .byte_valid     (byte_valid),
        .received_byte  (received_byte),
        .byte_last      (byte_last),
        .status_valid   (status_valid),
        .response_status(response_status),
        .pending        (pending),
        .fail_count     (fail_count),
        .words_checked  (words_checked),
        .bytes_checked  (bytes_checked),
        .ok_count       (ok_count),
        .bad_count      (bad_count),
        .silent_count   (silent_count)
    );

    always #5ns clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);

    // abort if neither channel moves a word for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // ticks a timed step lasts; zero behaves as one
    function automatic int span(logic [COUNTER_WIDTH-1:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1:       begin snd_idle_pct = 61; rcv_stall_pct = 0;  end
            2:       begin snd_idle_pct = 0;  rcv_stall_pct = 61; end
            default: begin snd_idle_pct = 9;  rcv_stall_pct = 9;  end
        endcase
    endtask

    // present one tick word and hold it until taken
    task automatic drive_tick(input logic req, input logic lvl);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_request <= req;
        line_level    <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // up to two high ticks, then the falling tick that releases an edge wait
    task automatic line_falls();
        repeat ($urandom_range(2))
            drive_tick(coin(), 1'b1);
        drive_tick(coin(), 1'b0);
    endtask

    // one transaction as the sensor would answer it; extra start requests land while busy
    task automatic run_frame(input logic [1:0] outcome);
        logic [7:0] value;
        drive_tick(1'b1, coin());
        repeat (span(stim_cfg.start_low_ticks) - 1)
            drive_tick(coin(), coin());
        repeat (span(stim_cfg.start_high_ticks))
            drive_tick(coin(), coin());
        repeat (span(stim_cfg.response_wait_ticks) - 1)
            drive_tick(coin(), coin());
        drive_tick(coin(), outcome == STATUS_NONE);
        if (outcome != STATUS_NONE)
        begin
            repeat (span(stim_cfg.response_check_ticks) - 1)
                drive_tick(coin(), coin());
            drive_tick(coin(), outcome == STATUS_OK);
        end
        line_falls();
        if (outcome == STATUS_OK)
        begin
            for (int n = 0; n < int'(stim_cfg.bytes_per_frame); n++)
            begin
                value = 8'($urandom_range(255));
                for (int b = 7; b >= 0; b--)
                begin
                    repeat ($urandom_range(2))
                        drive_tick(coin(), 1'b0);
                    drive_tick(coin(), 1'b1);
                    repeat (span(stim_cfg.bit_sample_ticks) - 1)
                        drive_tick(coin(), coin());
                    drive_tick(coin(), value[b]);
                    line_falls();
                end
            end
        end
    endtask

    // stop sending and let every owed result drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    // setup then access; psel stays up between back-to-back writes
    task automatic reg_write(input logic [IDX_WIDTH-1:0] idx, input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic apply_config(input swsr_cfg_t c);
        reg_write(REG_START_LOW,      DATA_WIDTH'(c.start_low_ticks));
        reg_write(REG_START_HIGH,     DATA_WIDTH'(c.start_high_ticks));
        reg_write(REG_RESPONSE_WAIT,  DATA_WIDTH'(c.response_wait_ticks));
        reg_write(REG_RESPONSE_CHECK, DATA_WIDTH'(c.response_check_ticks));
        reg_write(REG_BIT_SAMPLE,     DATA_WIDTH'(c.bit_sample_ticks));
        reg_write(REG_BYTES_FRAME,    DATA_WIDTH'(c.bytes_per_frame));
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        stim_cfg  = c;
        settings_applied++;
        @(posedge clk);
    endtask

    initial
    begin
        swsr_cfg_t  c;
        int         phase_base;
        int         pick;
        logic [1:0] outcome;

        stim_cfg = {RST_START_LOW, RST_START_HIGH, RST_RESPONSE_WAIT,
                    RST_RESPONSE_CHECK, RST_BIT_SAMPLE, RST_BYTES_FRAME};
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timings but for a short low pulse; the response comes back bad
        set_idling(0);
        stim_cfg.start_low_ticks = COUNTER_WIDTH'(3);
        reg_write(REG_START_LOW, DATA_WIDTH'(stim_cfg.start_low_ticks));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_applied++;
        @(posedge clk);
        run_frame(STATUS_BAD);

        // every timing register at zero, no bytes per frame
        settle();
        apply_config('0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
        run_frame(STATUS_NONE);
        run_frame(STATUS_BAD);
        run_frame(STATUS_OK);
        drive_tick(1'b0, 1'b1);
        run_frame(STATUS_OK);

        // random timings, mostly good frames with random bytes
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            c.start_low_ticks      = COUNTER_WIDTH'($urandom_range(6));
            c.start_high_ticks     = COUNTER_WIDTH'($urandom_range(6));
            c.response_wait_ticks  = COUNTER_WIDTH'($urandom_range(6));
            c.response_check_ticks = COUNTER_WIDTH'($urandom_range(6));
            c.bit_sample_ticks     = COUNTER_WIDTH'($urandom_range(4));
            if (ph == 3)
                c.bytes_per_frame = 4'($urandom_range(9, 15));
            else
                c.bytes_per_frame = 4'($urandom_range(3));
            apply_config(c);
            set_idling(ph % 4);
            phase_base = ticks_sent;
            while (ticks_sent - phase_base < PHASE_TICKS)
            begin
                repeat ($urandom_range(3))
                    drive_tick(1'b0, coin());
                pick = $urandom_range(99);
                if (pick < 70)
                    outcome = STATUS_OK;
                else if (pick < 85)
                    outcome = STATUS_NONE;
                else
                    outcome = STATUS_BAD;
                run_frame(outcome);
            end
        end

        settle();
        repeat (5)
            @(posedge clk);

        $display("%0d tick words sent, %0d result words compared over %0d register settings",
                 ticks_sent, words_checked, settings_applied);
        $display("%0d bytes received; responses: %0d ok, %0d bad, %0d silent",
                 bytes_checked, ok_count, bad_count, silent_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- single_wire_sensor_reader.f -----
sv/swsr_pkg.sv
sv/swsr_regs.sv
sv/single_wire_sensor_reader.sv
tb/swsr_tick_checker.sv
tb/tb_single_wire_sensor_reader.sv
